/* rtl/ssdd_pkg.sv */
// Shared types and constants for the seven-segment serial display driver.
// Used by the channel interfaces and the top level; depends on nothing.
package ssdd_pkg;

   typedef logic [1:0]  func_type;
   typedef logic [13:0] value_type;
   typedef logic [3:0]  level_type;
   typedef logic [7:0]  byte_type;

   localparam func_type FUNC_TICK    = 2'd0;
   localparam func_type FUNC_DISPLAY = 2'd1;
   localparam func_type FUNC_BRIGHT  = 2'd2;

   localparam byte_type CMD_DATA   = 8'h40;
   localparam byte_type CMD_ADDR   = 8'hC0;
   localparam byte_type CMD_BRIGHT = 8'h87;

   localparam level_type LEVEL_RESET = 4'd8;

   // Reciprocal of ten for a 14-bit dividend: q = (v * RECIP_TEN) >> RECIP_SHIFT.
   localparam logic [15:0] RECIP_TEN   = 16'hCCCD;
   localparam int          RECIP_SHIFT = 19;

   typedef struct packed {
      logic clk_line;
      logic dio_line;
      logic busy_res;
   } rsp_type;

   function automatic byte_type seg_pattern(input logic [3:0] digit);
      byte_type pat;
      case (digit)
         4'd0:    pat = 8'h3f;
         4'd1:    pat = 8'h06;
         4'd2:    pat = 8'h5b;
         4'd3:    pat = 8'h4f;
         4'd4:    pat = 8'h66;
         4'd5:    pat = 8'h6d;
         4'd6:    pat = 8'h7d;
         4'd7:    pat = 8'h07;
         4'd8:    pat = 8'h7f;
         4'd9:    pat = 8'h6f;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

endpackage

/* rtl/ssdd_req_if.sv */
// Request channel of the display driver: valid, ready, function code and value.
// Depends on ssdd_pkg.
interface ssdd_req_if;
   import ssdd_pkg::*;

   logic      valid;
   logic      ready;
   func_type  func;
   value_type value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

/* rtl/ssdd_rsp_if.sv */
// Response channel of the display driver: valid, ready and the line levels.
// Depends on ssdd_pkg.
interface ssdd_rsp_if;
   import ssdd_pkg::*;

   logic valid;
   logic ready;
   logic clk_line;
   logic dio_line;
   logic busy_res;

   modport source (output valid, output clk_line, output dio_line, output busy_res,
                   input ready);
   modport sink   (input valid, input clk_line, input dio_line, input busy_res,
                   output ready);
endinterface

/* rtl/seven_segment_serial_display_driver.sv */
// Two-wire seven-segment display driver: frame sequencer and output buffer.
// Depends on ssdd_pkg, ssdd_req_if and ssdd_rsp_if.
//
// Each request is one microsecond tick of the serial waveform and yields one
// response giving the clock and data pin levels for that tick, plus a busy
// flag. One request is taken every cycle while the skid entry is free; each
// response goes into the output register, or into the skid entry of the
// two-entry output buffer while the output register holds an untaken one, so
// one more request is taken while a response waits. A display frame converts
// its value to decimal one digit per request over the next DIGIT_COUNT requests
// by a reciprocal-of-ten multiply, long before any segment byte is sent.
module seven_segment_serial_display_driver #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  ssdd_pkg::level_type csr_wr_data,
   ssdd_req_if.sink            req_if,
   ssdd_rsp_if.source          rsp_if
);
   import ssdd_pkg::*;

   localparam int CNT_W = $clog2(DIGIT_COUNT + 1);
   localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam logic [2:0] LAST_BYTE = 3'(DIGIT_COUNT + 1);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_START = 3'd1;
   localparam logic [2:0] PH_BITS  = 3'd2;
   localparam logic [2:0] PH_ACK   = 3'd3;
   localparam logic [2:0] PH_STOP  = 3'd4;

   level_type  level_ff;
   logic [2:0] phase_ff, phase_in;
   logic [2:0] bit_ff, bit_in;
   logic [2:0] byte_ff, byte_in;
   logic [2:0] hold_ff, hold_in;
   byte_type   shift_ff, shift_in;
   logic       kind_ff, kind_in;
   logic       clk_lvl_ff, clk_lvl_in;
   logic       dio_lvl_ff, dio_lvl_in;
   value_type  val_ff, val_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   byte_type   dig_ff [DIGIT_COUNT];
   byte_type   dig_in [DIGIT_COUNT];

   rsp_type    out_ff, skid_ff, result;
   logic       out_valid_ff, skid_valid_ff;
   logic       push, pop;

   logic [29:0] prod;
   value_type   quot;
   value_type   rem;
   byte_type    bright_byte;
   logic [2:0]  next_byte;
   logic [POS_W-1:0] dig_pos;

   assign req_if.ready = !skid_valid_ff;
   assign push = req_if.valid && req_if.ready;
   assign pop  = out_valid_ff && rsp_if.ready;

   assign prod        = 30'(val_ff) * 30'(RECIP_TEN);
   assign quot        = 14'(prod[29:RECIP_SHIFT]);
   assign rem         = val_ff - 14'(quot * 14'd10);
   assign bright_byte = CMD_BRIGHT + 8'(level_ff);
   assign next_byte   = byte_ff + 3'd1;
   assign dig_pos     = POS_W'(byte_ff - 3'd1);

   always_comb begin
      phase_in   = phase_ff;
      bit_in     = bit_ff;
      byte_in    = byte_ff;
      hold_in    = hold_ff;
      shift_in   = shift_ff;
      kind_in    = kind_ff;
      val_in     = val_ff;
      cnt_in     = cnt_ff;
      dig_in     = dig_ff;
      clk_lvl_in = clk_lvl_ff;
      dio_lvl_in = dio_lvl_ff;

      if (cnt_ff != '0) begin
         dig_in[0] = seg_pattern(rem[3:0]);
         for (int i = 1; i < DIGIT_COUNT; i++) begin
            dig_in[i] = dig_ff[i-1];
         end
         val_in = quot;
         cnt_in = cnt_ff - CNT_W'(1);
      end

      if (phase_ff == PH_IDLE && (req_if.func == FUNC_DISPLAY || req_if.func == FUNC_BRIGHT)) begin
         if (req_if.func == FUNC_DISPLAY) begin
            kind_in  = 1'b1;
            val_in   = req_if.value;
            cnt_in   = CNT_W'(DIGIT_COUNT);
            shift_in = CMD_DATA;
         end else begin
            kind_in  = 1'b0;
            shift_in = bright_byte;
         end
         phase_in = PH_START;
         hold_in  = 3'd0;
         bit_in   = 3'd0;
         byte_in  = 3'd0;
      end

      result.busy_res = (phase_in != PH_IDLE);
      result.clk_line = clk_lvl_ff;
      result.dio_line = dio_lvl_ff;

      case (phase_in)
         PH_IDLE: begin
         end
         PH_START: begin
            result.clk_line = 1'b1;
            result.dio_line = (hold_in < 3'd2);
            if (hold_in >= 3'd2) begin
               phase_in = PH_BITS;
               hold_in  = 3'd0;
               bit_in   = 3'd0;
            end else begin
               hold_in = hold_in + 3'd1;
            end
         end
         PH_BITS: begin
            result.clk_line = (hold_in >= 3'd3);
            result.dio_line = shift_in[0];
            if (hold_in >= 3'd5) begin
               hold_in  = 3'd0;
               shift_in = shift_in >> 1;
               if (bit_in >= 3'd7) begin
                  bit_in   = 3'd0;
                  phase_in = PH_ACK;
               end else begin
                  bit_in = bit_in + 3'd1;
               end
            end else begin
               hold_in = hold_in + 3'd1;
            end
         end
         PH_ACK: begin
            result.clk_line = (hold_in == 3'd5 || hold_in == 3'd6);
            result.dio_line = dio_lvl_ff;
            if (hold_in >= 3'd7) begin
               hold_in = 3'd0;
               if (kind_in && byte_in >= 3'd1 && byte_in < LAST_BYTE) begin
                  byte_in  = next_byte;
                  shift_in = dig_ff[dig_pos];
                  bit_in   = 3'd0;
                  phase_in = PH_BITS;
               end else begin
                  phase_in = PH_STOP;
               end
            end else begin
               hold_in = hold_in + 3'd1;
            end
         end
         PH_STOP: begin
            result.clk_line = (hold_in >= 3'd2);
            result.dio_line = (hold_in >= 3'd4);
            if (hold_in >= 3'd4) begin
               if (kind_in && byte_in == 3'd0) begin
                  phase_in = PH_START;
                  hold_in  = 3'd0;
                  bit_in   = 3'd0;
                  byte_in  = 3'd1;
                  shift_in = CMD_ADDR;
               end else begin
                  phase_in = PH_IDLE;
                  hold_in  = 3'd0;
                  bit_in   = 3'd0;
                  byte_in  = 3'd0;
               end
            end else begin
               hold_in = hold_in + 3'd1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      clk_lvl_in = result.clk_line;
      dio_lvl_in = result.dio_line;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= LEVEL_RESET;
      end else if (csr_wr_en) begin
         level_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         bit_ff     <= 3'd0;
         byte_ff    <= 3'd0;
         hold_ff    <= 3'd0;
         shift_ff   <= 8'd0;
         kind_ff    <= 1'b0;
         clk_lvl_ff <= 1'b1;
         dio_lvl_ff <= 1'b1;
         cnt_ff     <= '0;
      end else if (push) begin
         phase_ff   <= phase_in;
         bit_ff     <= bit_in;
         byte_ff    <= byte_in;
         hold_ff    <= hold_in;
         shift_ff   <= shift_in;
         kind_ff    <= kind_in;
         clk_lvl_ff <= clk_lvl_in;
         dio_lvl_ff <= dio_lvl_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         val_ff <= val_in;
         dig_ff <= dig_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
            out_ff       <= result;
         end
      end else if (!out_valid_ff) begin
         out_valid_ff <= push;
         out_ff       <= result;
      end else if (push) begin
         skid_ff       <= result;
         skid_valid_ff <= 1'b1;
      end
   end

   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.clk_line = out_ff.clk_line;
   assign rsp_if.dio_line = out_ff.dio_line;
   assign rsp_if.busy_res = out_ff.busy_res;

endmodule

/* tb/sv/seven_segment_serial_display_driver_tb.sv */
// Self-checking testbench for the two-wire seven-segment display driver.
// Depends on ssdd_pkg, ssdd_req_if, ssdd_rsp_if and the driver top level;
// it predicts the pin levels of every tick and checks each response in order.
module seven_segment_serial_display_driver_tb;
   import ssdd_pkg::*;

   localparam int DIGITS = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_TICKS = 75;
   localparam func_type FUNC_UNUSED = 2'd3;

   localparam logic [2:0] SEQ_IDLE  = 3'd0;
   localparam logic [2:0] SEQ_START = 3'd1;
   localparam logic [2:0] SEQ_BITS  = 3'd2;
   localparam logic [2:0] SEQ_ACK   = 3'd3;
   localparam logic [2:0] SEQ_STOP  = 3'd4;

   typedef struct packed {
      func_type  func;
      value_type value;
   } tick_cmd_type;

   localparam byte_type SEG_CODES [10] = '{
      8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
   };

   logic      clock;
   logic      reset;
   logic      csr_wr_en;
   level_type csr_wr_data;

   ssdd_req_if req_if ();
   ssdd_rsp_if rsp_if ();

   seven_segment_serial_display_driver #(
      .DIGIT_COUNT (DIGITS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_if),
      .rsp_if      (rsp_if)
   );

   // Predicted state of the frame sequencer.
   logic [2:0] seq_phase = SEQ_IDLE;
   int         bit_cnt = 0;
   int         byte_num = 0;
   int         hold_cnt = 0;
   byte_type   shift_reg = '0;
   byte_type   seg_store [DIGITS];
   logic       display_frame = 1'b0;
   logic       clk_level = 1'b1;
   logic       dio_level = 1'b1;
   level_type  bright_level = LEVEL_RESET;

   tick_cmd_type ticks_to_send [$];
   rsp_type      line_levels_due [$];
   int           errors = 0;
   int           burst_left = 0;
   int           gap_left = 0;
   int           rx_mode = 0;
   int           rx_mode_left = 0;
   int           rx_count = 0;
   int           holdoff_left = 0;
   bit           holdoff_wanted = 1'b0;
   bit           holdoff_done = 1'b0;
   int           quiet_cycles = 0;
   tick_cmd_type next_cmd;
   rsp_type      want;

   always #5 clock = ~clock;

   function automatic byte_type frame_byte_at(int k);
      if (!display_frame) return byte_type'(CMD_BRIGHT + bright_level);
      if (k == 0) return CMD_DATA;
      if (k == 1) return CMD_ADDR;
      if (k - 2 < DIGITS) return seg_store[DIGITS - 1 - (k - 2)];
      return '0;
   endfunction

   function automatic void open_byte(int k);
      seq_phase = SEQ_START;
      hold_cnt  = 0;
      bit_cnt   = 0;
      byte_num  = k;
      shift_reg = frame_byte_at(k);
   endfunction

   function automatic rsp_type predict_tick_levels(func_type f, value_type v);
      rsp_type     r;
      int unsigned num;
      int          i;
      logic        lc;
      logic        ld;
      logic        busy;
      num = v;
      lc  = clk_level;
      ld  = dio_level;
      if (seq_phase == SEQ_IDLE && (f == FUNC_DISPLAY || f == FUNC_BRIGHT)) begin
         if (f == FUNC_DISPLAY) begin
            display_frame = 1'b1;
            for (i = 0; i < DIGITS; i++) begin
               seg_store[i] = SEG_CODES[num % 10];
               num = num / 10;
            end
         end else begin
            display_frame = 1'b0;
         end
         open_byte(0);
      end
      busy = (seq_phase != SEQ_IDLE);
      case (seq_phase)
         SEQ_START: begin
            lc = 1'b1;
            ld = (hold_cnt < 2);
            if (hold_cnt >= 2) begin
               seq_phase = SEQ_BITS;
               hold_cnt  = 0;
               bit_cnt   = 0;
            end else begin
               hold_cnt++;
            end
         end
         SEQ_BITS: begin
            lc = (hold_cnt >= 3);
            ld = shift_reg[0];
            if (hold_cnt >= 5) begin
               hold_cnt  = 0;
               shift_reg = shift_reg >> 1;
               if (bit_cnt >= 7) begin
                  bit_cnt   = 0;
                  seq_phase = SEQ_ACK;
               end else begin
                  bit_cnt++;
               end
            end else begin
               hold_cnt++;
            end
         end
         SEQ_ACK: begin
            lc = (hold_cnt >= 5 && hold_cnt <= 6);
            ld = dio_level;
            if (hold_cnt >= 7) begin
               hold_cnt = 0;
               if (display_frame && byte_num >= 1 && byte_num < DIGITS + 1) begin
                  byte_num++;
                  shift_reg = frame_byte_at(byte_num);
                  bit_cnt   = 0;
                  seq_phase = SEQ_BITS;
               end else begin
                  seq_phase = SEQ_STOP;
               end
            end else begin
               hold_cnt++;
            end
         end
         SEQ_STOP: begin
            lc = (hold_cnt >= 2);
            ld = (hold_cnt >= 4);
            if (hold_cnt >= 4) begin
               if (display_frame && byte_num == 0) begin
                  open_byte(1);
               end else begin
                  seq_phase = SEQ_IDLE;
                  hold_cnt  = 0;
                  bit_cnt   = 0;
                  byte_num  = 0;
               end
            end else begin
               hold_cnt++;
            end
         end
         default: seq_phase = SEQ_IDLE;
      endcase
      clk_level  = lc;
      dio_level  = ld;
      r.clk_line = lc;
      r.dio_line = ld;
      r.busy_res = busy;
      return r;
   endfunction

   task automatic queue_tick(func_type f, value_type v);
      ticks_to_send.push_back('{func: f, value: v});
   endtask

   task automatic play_frame(func_type f, value_type v, int n, bit noisy);
      int i;
      queue_tick(f, v);
      for (i = 1; i < n; i++) begin
         if (noisy && i % 40 == 0)
            queue_tick(func_type'($urandom_range(1, 3)), value_type'($urandom_range(0, 16383)));
         else
            queue_tick(FUNC_TICK, value_type'($urandom_range(0, 16383)));
      end
   endtask

   task automatic wait_for_drain();
      while (ticks_to_send.size() != 0 || req_if.valid || line_levels_due.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_level(level_type lvl);
      wait_for_drain();
      @(posedge clock);
      csr_wr_en    <= 1'b1;
      csr_wr_data  <= lvl;
      bright_level = lvl;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            line_levels_due.push_back(predict_tick_levels(req_if.func, req_if.value));
         if (!(req_if.valid && !req_if.ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (ticks_to_send.size() == 0) begin
               req_if.valid <= 1'b0;
            end else begin
               next_cmd = ticks_to_send.pop_front();
               req_if.valid <= 1'b1;
               req_if.func  <= next_cmd.func;
               req_if.value <= next_cmd.value;
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // Receiver: its own stall pattern, with one long hold-off on request.
   always @(posedge clock) begin
      rx_count++;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_if.ready <= 1'b0;
      end else if (holdoff_wanted && !holdoff_done) begin
         holdoff_done = 1'b1;
         holdoff_left = HOLDOFF_CYCLES - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(20, 120);
         end
         rx_mode_left--;
         case (rx_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= ($urandom_range(0, 99) < 60);
            default: rsp_if.ready <= (rx_count % 4 == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (line_levels_due.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            want = line_levels_due.pop_front();
            if (want.clk_line !== rsp_if.clk_line) begin
               $error("clk_line: expected %0b, actual %0b", want.clk_line, rsp_if.clk_line);
               errors++;
            end
            if (want.dio_line !== rsp_if.dio_line) begin
               $error("dio_line: expected %0b, actual %0b", want.dio_line, rsp_if.dio_line);
               errors++;
            end
            if (want.busy_res !== rsp_if.busy_res) begin
               $error("busy_res: expected %0b, actual %0b", want.busy_res, rsp_if.busy_res);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("seven_segment_serial_display_driver regression: fail");
            $finish;
         end
      end
   end

   initial begin
      int        phase_idx;
      int        i;
      int        pick;
      level_type lvl;
      clock        = 1'b0;
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = LEVEL_RESET;
      req_if.valid = 1'b0;
      req_if.func  = FUNC_TICK;
      req_if.value = '0;
      rsp_if.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      play_frame(FUNC_BRIGHT, 14'h3fff, 70, 1'b0);
      play_frame(FUNC_DISPLAY, 14'h3fff, 360, 1'b1);
      play_frame(FUNC_UNUSED, 14'd1234, 5, 1'b0);
      write_level(4'd0);
      play_frame(FUNC_BRIGHT, 14'd0, 70, 1'b0);
      write_level(4'd15);
      play_frame(FUNC_BRIGHT, 14'h2aaa, 70, 1'b0);
      // A register write part-way through a brightness frame leaves its byte alone.
      play_frame(FUNC_BRIGHT, 14'h1555, 21, 1'b0);
      write_level(4'd1);
      play_frame(FUNC_TICK, 14'd0, 50, 1'b0);

      for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
         case (phase_idx)
            0:       lvl = 4'd8;
            1:       lvl = 4'd0;
            2:       lvl = 4'd15;
            default: lvl = level_type'($urandom_range(0, 15));
         endcase
         write_level(lvl);
         if (phase_idx == 1)
            holdoff_wanted = 1'b1;
         for (i = 0; i < PHASE_TICKS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 88)
               queue_tick(FUNC_TICK, value_type'($urandom_range(0, 16383)));
            else if (pick < 93)
               queue_tick(FUNC_DISPLAY, ($urandom_range(0, 9) < 7)
                          ? value_type'($urandom_range(0, 9999))
                          : value_type'($urandom_range(10000, 16383)));
            else if (pick < 98)
               queue_tick(FUNC_BRIGHT, value_type'($urandom_range(0, 16383)));
            else
               queue_tick(FUNC_UNUSED, value_type'($urandom_range(0, 16383)));
         end
      end

      wait_for_drain();
      repeat (10) @(negedge clock);
      if (line_levels_due.size() != 0) begin
         $error("%0d responses never arrived", line_levels_due.size());
         errors++;
      end
      if (errors == 0)
         $display("seven_segment_serial_display_driver regression: pass");
      else
         $display("seven_segment_serial_display_driver regression: fail");
      $finish;
   end

endmodule
